@@ rtl/sida_pkg.sv @@
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants for the decimal text converter
// Command/status structs between controller and datapath, ASCII codes.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int          CHAR_W     = 6;
  localparam int          TOTAL_W    = 4;
  localparam int          OUT_DATA_W = 16;  // char_code + char_total, byte padded

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture a new value, start conversion
    logic conv;         // one double-dabble step
    logic shift_dig;    // drop the top BCD digit
    logic latch_total;  // freeze the run length
    logic sign_out;     // present the minus sign on the output
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic conv_last;    // final conversion step this cycle
    logic top_zero;     // top BCD digit is zero
    logic one_left;     // one digit remains
    logic neg;          // value is negative
  } dp_stat_t;

endpackage

@@ rtl/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Stream in one two's complement value, stream out its decimal characters.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one word per value, the integer in the low DATA_WIDTH bits.
//   m_axis: one word per character, most significant first. A negative value
//     begins with '-', zero gives "0", no leading zeros. tlast marks the final
//     character; every word also carries the run length (char_total).
// Timing:
//   One value at a time. After accept the magnitude goes through a
//   shift-and-add-3 BCD converter, one input bit per cycle, then leading
//   zero digits are dropped one per cycle, then one character per cycle
//   leaves while m_axis_tready is high. s_axis_tready is high only while
//   idle.
// Reset: synchronous, returns to idle; any run in progress is dropped.
// Stall: a character held by a low tready stays stable until taken.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [DATA_WIDTH-1:0] value, rest zero padding
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [5:0] char_code, [9:6] char_total, [15:10] zero
  output logic [sida_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int PAD_W = sida_pkg::OUT_DATA_W - sida_pkg::CHAR_W - sida_pkg::TOTAL_W;

  sida_pkg::dp_cmd_t                cmd;
  sida_pkg::dp_stat_t               stat;
  logic [sida_pkg::CHAR_W-1:0]      char_code;
  logic [sida_pkg::TOTAL_W-1:0]     char_total;

  sida_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sida_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .value      (s_axis_tdata[DATA_WIDTH-1:0]),
    .cmd        (cmd),
    .stat       (stat),
    .char_code  (char_code),
    .last       (m_axis_tlast),
    .char_total (char_total)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, char_total, char_code};

endmodule

@@ rtl/sida_dp.sv @@
// ----------------------------------------------------------------------------
// sida_dp: conversion datapath
// Shift-and-add-3 binary to BCD, leading zero trim, character formatting.
// ----------------------------------------------------------------------------
module sida_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic [DATA_WIDTH-1:0]            value,
  input  sida_pkg::dp_cmd_t                cmd,
  output sida_pkg::dp_stat_t               stat,
  output logic [sida_pkg::CHAR_W-1:0]      char_code,
  output logic                             last,
  output logic [sida_pkg::TOTAL_W-1:0]     char_total
);

  // digits of 2**(DATA_WIDTH-1): floor((W-1)*log10(2)) + 1
  localparam int NDIG  = ((DATA_WIDTH - 1) * 1233) / 4096 + 1;
  localparam int BCD_W = 4 * NDIG;
  localparam int CNT_W = $clog2(DATA_WIDTH + 1);
  localparam int DIG_W = $clog2(NDIG + 1);

  logic [DATA_WIDTH-1:0]          mag;
  logic [BCD_W-1:0]               bcd;
  logic [CNT_W-1:0]               bitcnt;
  logic [DIG_W-1:0]               ndig;
  logic                           neg;
  logic [sida_pkg::TOTAL_W-1:0]   total;

  logic [BCD_W-1:0]               bcd_adj;
  logic [DATA_WIDTH-1:0]          mag_in;
  logic [4:0]                     total_sum;
  logic [3:0]                     top_dig;

  assign mag_in = value[DATA_WIDTH-1] ? (~value + 1'b1) : value;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag    <= mag_in;
      neg    <= value[DATA_WIDTH-1];
      bcd    <= '0;
      bitcnt <= CNT_W'(DATA_WIDTH);
      ndig   <= DIG_W'(NDIG);
    end else if (cmd.conv) begin
      bcd    <= {bcd_adj[BCD_W-2:0], mag[DATA_WIDTH-1]};
      mag    <= {mag[DATA_WIDTH-2:0], 1'b0};
      bitcnt <= bitcnt - 1'b1;
    end else if (cmd.shift_dig) begin
      bcd    <= {bcd[BCD_W-5:0], 4'd0};
      ndig   <= ndig - 1'b1;
    end
    if (cmd.latch_total) begin
      total <= total_sum[sida_pkg::TOTAL_W-1:0];
    end
  end

  assign total_sum = 5'(ndig) + 5'(neg);
  assign top_dig   = bcd[BCD_W-1 -: 4];

  assign stat.conv_last = (bitcnt == CNT_W'(1));
  assign stat.top_zero  = (top_dig == 4'd0);
  assign stat.one_left  = (ndig == DIG_W'(1));
  assign stat.neg       = neg;

  // digits are 0..9, so '0' + d is an OR into the low nibble
  assign char_code  = cmd.sign_out ? sida_pkg::CHAR_MINUS
                                   : (sida_pkg::CHAR_ZERO | {2'b00, top_dig});
  // the sign is never the only character
  assign last       = !cmd.sign_out && stat.one_left;
  assign char_total = total;

endmodule

@@ rtl/sida_ctrl.sv @@
// ----------------------------------------------------------------------------
// sida_ctrl: sequencing for the decimal text converter
// Accept, convert, trim leading zeros, emit sign and digits.
// ----------------------------------------------------------------------------
module sida_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sida_pkg::dp_stat_t  stat,
  output sida_pkg::dp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_TRIM  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (stat.conv_last) state_next = ST_TRIM;
      end
      ST_TRIM: begin
        if (stat.top_zero && !stat.one_left) begin
          cmd.shift_dig = 1'b1;
        end else begin
          cmd.latch_total = 1'b1;
          state_next      = stat.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.sign_out = 1'b1;
        if (out_ready) state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.one_left) begin
            state_next = ST_IDLE;
          end else begin
            cmd.shift_dig = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/sida_checker.sv @@
// ----------------------------------------------------------------------------
// sida_checker: port-level checks for the decimal text converter
// One value in flight at a time; runs are emitted without gaps.
// ----------------------------------------------------------------------------
module sida_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [((DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [sida_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input logic                               m_axis_tlast
);

  // offered input word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input word changed before accept");

  // never accepting while a character is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed under stall");

  // characters of one run follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a character run");

  // back to idle right after the final character
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not ready after end of run");

endmodule

bind signed_int_to_decimal_ascii sida_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_sida_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
